// ----- sv/priority_heap_queue_assert.svh -----
// assertion macros for the priority heap queue
// no dependencies; taken in by the files that check their own logic
`ifndef PRIORITY_HEAP_QUEUE_ASSERT_SVH
`define PRIORITY_HEAP_QUEUE_ASSERT_SVH

// same-cycle implication, off while reset is low
`define PHQ_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off while reset is low
`define PHQ_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/phq_pkg.sv -----
// shared types and constants of the priority heap queue
// no dependencies; imported by phq_cmp and priority_heap_queue (phq_ram does not import it)
package phq_pkg;

  localparam int KEY_W     = 26;
  localparam int PAY_W     = 16;
  localparam int ENTRY_W   = KEY_W + PAY_W;
  localparam int CNT_OUT_W = 7;
  localparam int IN_W      = 48;
  localparam int OUT_W     = 56;

  typedef enum logic [1:0] {
    OP_INSERT  = 2'd0,
    OP_PEEK    = 2'd1,
    OP_EXTRACT = 2'd2
  } opcode_t;

  typedef enum logic [1:0] {
    STS_OK    = 2'd0,
    STS_EMPTY = 2'd1,
    STS_FULL  = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_UP_RD,
    S_UP_CMP,
    S_TOP,
    S_LAST,
    S_DN_RDL,
    S_DN_RDR,
    S_DN_CMP,
    S_FIN
  } state_t;

  // operand routing of the shared key comparator
  typedef enum logic [1:0] {
    CMP_MV_RD,
    CMP_RD_MV,
    CMP_RD_BEST
  } cmp_sel_t;

endpackage

// ----- sv/phq_ram.sv -----
// generic simple dual-port ram, one write port and one registered read port
// no dependencies; holds the heap entries
module phq_ram #(
  parameter int WIDTH = 42,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- sv/phq_cmp.sv -----
// shared key comparator of the heap sift sequencer
// depends on phq_pkg for the entry layout and operand select codes
module phq_cmp
  import phq_pkg::*;
(
  input  cmp_sel_t           sel,
  input  logic [ENTRY_W-1:0] mv_entry,
  input  logic [ENTRY_W-1:0] rd_entry,
  input  logic [ENTRY_W-1:0] best_entry,
  output logic               gt
);

  logic [KEY_W-1:0] key_a;
  logic [KEY_W-1:0] key_b;

  always_comb begin
    case (sel)
      CMP_MV_RD: begin
        key_a = mv_entry[ENTRY_W-1:PAY_W];
        key_b = rd_entry[ENTRY_W-1:PAY_W];
      end
      CMP_RD_MV: begin
        key_a = rd_entry[ENTRY_W-1:PAY_W];
        key_b = mv_entry[ENTRY_W-1:PAY_W];
      end
      CMP_RD_BEST: begin
        key_a = rd_entry[ENTRY_W-1:PAY_W];
        key_b = best_entry[ENTRY_W-1:PAY_W];
      end
      default: begin
        key_a = '0;
        key_b = '0;
      end
    endcase
  end

  // key is category, year, month, day from the top bit down
  assign gt = key_a > key_b;

endmodule

// ----- sv/priority_heap_queue.sv -----
// channel | dir | tdata fields, lowest bit first
// in_     | in  | opcode[1:0] category[4:2] year[18:5] month[22:19] day[27:23] payload_tag[43:28]
// out_    | out | status[1:0] top_category[4:2] top_year[18:5] top_month[22:19]
//         |     |   top_day[27:23] top_payload[43:28] entry_count[50:44]
// insert sifts up from the next free leaf to where it stops; peek reads the root only
// extract reads the root, then the last entry, then sifts down; a single entry needs only the root
// a climbed level costs one ram read and one compare, a descended level up to two of each
// one transaction in flight; a finished result waits in the output register
// rst_n (synchronous) empties the heap; the ram holds no reset value
// the block waits in its last step while the output register is still full
// top level of the priority heap queue: sift sequencer, heap ram and comparator
// depends on phq_pkg, phq_ram, phq_cmp and priority_heap_queue_assert.svh
`include "priority_heap_queue_assert.svh"

module priority_heap_queue
  import phq_pkg::*;
#(
  parameter int CAPACITY = 64
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [IN_W-1:0]  in_tdata,   // opcode, category, year, month, day, payload_tag
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [OUT_W-1:0] out_tdata   // status, top_category, top_year, top_month,
                                       // top_day, top_payload, entry_count
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int XW = AW + 2;

  state_t               state_r, state_nxt;
  logic [AW-1:0]        pos_r, pos_nxt;
  logic [CW-1:0]        cnt_r, cnt_nxt;
  logic [ENTRY_W-1:0]   mv_r, mv_nxt;
  logic [ENTRY_W-1:0]   best_r, best_nxt;
  logic [AW-1:0]        bidx_r, bidx_nxt;
  logic                 bchild_r, bchild_nxt;
  logic                 rhas_r, rhas_nxt;
  logic [ENTRY_W-1:0]   top_r, top_nxt;
  logic [1:0]           op_r, op_nxt;
  status_t              sts_r, sts_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0]     out_data_r, out_data_nxt;

  logic                 we;
  logic [AW-1:0]        waddr;
  logic [ENTRY_W-1:0]   wdata;
  logic [AW-1:0]        raddr;
  logic [ENTRY_W-1:0]   rdata;
  cmp_sel_t             cmp_sel;
  logic                 gt;

  logic                 in_acc;
  logic [1:0]           in_op;
  logic [ENTRY_W-1:0]   in_entry;
  logic [XW-1:0]        lchild;
  logic [XW-1:0]        rchild;
  logic [XW-1:0]        cnt_x;
  logic [AW-1:0]        parent;
  logic                 full;

  assign in_acc   = in_tvalid && in_tready;
  assign in_op    = in_tdata[1:0];
  // entry layout: category, year, month, day, payload from the top down
  assign in_entry = {in_tdata[4:2], in_tdata[18:5], in_tdata[22:19], in_tdata[27:23],
                     in_tdata[43:28]};

  assign lchild = (XW'(pos_r) << 1) + XW'(1);
  assign rchild = lchild + XW'(1);
  assign cnt_x  = XW'(cnt_r);
  assign parent = (pos_r - AW'(1)) >> 1;
  assign full   = cnt_r == CW'(CAPACITY);

  phq_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  phq_cmp u_cmp (
    .sel        (cmp_sel),
    .mv_entry   (mv_r),
    .rd_entry   (rdata),
    .best_entry (best_r),
    .gt         (gt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r      <= pos_nxt;
    mv_r       <= mv_nxt;
    best_r     <= best_nxt;
    bidx_r     <= bidx_nxt;
    bchild_r   <= bchild_nxt;
    rhas_r     <= rhas_nxt;
    top_r      <= top_nxt;
    op_r       <= op_nxt;
    sts_r      <= sts_nxt;
    out_data_r <= out_data_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    pos_nxt       = pos_r;
    cnt_nxt       = cnt_r;
    mv_nxt        = mv_r;
    best_nxt      = best_r;
    bidx_nxt      = bidx_r;
    bchild_nxt    = bchild_r;
    rhas_nxt      = rhas_r;
    top_nxt       = top_r;
    op_nxt        = op_r;
    sts_nxt       = sts_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    in_tready     = 1'b0;
    we            = 1'b0;
    waddr         = pos_r;
    wdata         = mv_r;
    raddr         = '0;
    cmp_sel       = CMP_MV_RD;

    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_acc) begin
          op_nxt  = in_op;
          top_nxt = '0;
          sts_nxt = STS_OK;
          mv_nxt  = in_entry;
          case (in_op)
            OP_INSERT: begin
              if (full) begin
                sts_nxt   = STS_FULL;
                state_nxt = S_FIN;
              end else begin
                pos_nxt   = AW'(cnt_r);
                cnt_nxt   = cnt_r + CW'(1);
                state_nxt = S_UP_RD;
              end
            end
            OP_PEEK, OP_EXTRACT: begin
              if (cnt_r == '0) begin
                sts_nxt   = STS_EMPTY;
                state_nxt = S_FIN;
              end else begin
                state_nxt = S_TOP;
              end
            end
            default: state_nxt = S_FIN;
          endcase
        end
      end

      S_UP_RD: begin
        if (pos_r == '0) begin
          we        = 1'b1;
          state_nxt = S_FIN;
        end else begin
          raddr     = parent;
          state_nxt = S_UP_CMP;
        end
      end

      S_UP_CMP: begin
        cmp_sel = CMP_MV_RD;
        we      = 1'b1;
        if (gt) begin
          // parent drops into the hole, hole climbs
          wdata     = rdata;
          pos_nxt   = parent;
          state_nxt = S_UP_RD;
        end else begin
          state_nxt = S_FIN;
        end
      end

      S_TOP: begin
        top_nxt = rdata;
        if (op_r == OP_EXTRACT) begin
          cnt_nxt = cnt_r - CW'(1);
          if (cnt_r == CW'(1)) begin
            state_nxt = S_FIN;
          end else begin
            raddr     = AW'(cnt_r - CW'(1));
            state_nxt = S_LAST;
          end
        end else begin
          state_nxt = S_FIN;
        end
      end

      S_LAST: begin
        mv_nxt    = rdata;
        pos_nxt   = '0;
        state_nxt = S_DN_RDL;
      end

      S_DN_RDL: begin
        if (lchild >= cnt_x) begin
          we        = 1'b1;
          state_nxt = S_FIN;
        end else begin
          raddr     = AW'(lchild);
          state_nxt = S_DN_RDR;
        end
      end

      S_DN_RDR: begin
        cmp_sel = CMP_RD_MV;
        if (gt) begin
          best_nxt   = rdata;
          bidx_nxt   = AW'(lchild);
          bchild_nxt = 1'b1;
        end else begin
          best_nxt   = mv_r;
          bidx_nxt   = pos_r;
          bchild_nxt = 1'b0;
        end
        rhas_nxt = rchild < cnt_x;
        if (rchild < cnt_x) begin
          raddr = AW'(rchild);
        end
        state_nxt = S_DN_CMP;
      end

      S_DN_CMP: begin
        cmp_sel = CMP_RD_BEST;
        we      = 1'b1;
        if (rhas_r && gt) begin
          wdata     = rdata;
          pos_nxt   = AW'(rchild);
          state_nxt = S_DN_RDL;
        end else if (bchild_r) begin
          wdata     = best_r;
          pos_nxt   = bidx_r;
          state_nxt = S_DN_RDL;
        end else begin
          state_nxt = S_FIN;
        end
      end

      S_FIN: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {5'd0, CNT_OUT_W'(cnt_nxt), top_r[PAY_W-1:0], top_r[20:16],
                           top_r[24:21], top_r[38:25], top_r[41:39], sts_r};
          state_nxt     = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  `PHQ_ASSERT_NOW(a_cnt_bound, clk, rst_n, 1'b1, cnt_r <= CW'(CAPACITY),
    "entry count beyond capacity")

  `PHQ_ASSERT_NOW(a_wr_in_range, clk, rst_n, we, XW'(waddr) < cnt_x,
    "heap write outside the held entries")

  `PHQ_ASSERT_NEXT(a_ins_count, clk, rst_n, in_acc && in_op == OP_INSERT && !full,
    cnt_r == $past(cnt_r) + CW'(1), "accepted insert did not grow the heap")

  `PHQ_ASSERT_NOW(a_no_wr_idle, clk, rst_n, state_r == S_IDLE || state_r == S_FIN, !we,
    "heap write outside a sift step")

endmodule
